// ----- hw/rtl/pef_pkg.sv -----
package pef_pkg;

   // request codes
   localparam logic [1:0] FUNC_ENQUEUE = 2'd0;
   localparam logic [1:0] FUNC_SERVICE = 2'd1;
   localparam logic [1:0] FUNC_CLEAR   = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_ACCEPTED = 2'd0;
   localparam logic [1:0] KIND_REFUSED  = 2'd1;
   localparam logic [1:0] KIND_RELEASED = 2'd2;
   localparam logic [1:0] KIND_NONE     = 2'd3;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_ALL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GAP  = 2'd1;
   localparam int CSR_DATA_W = 16;

   localparam logic [15:0] MIN_GAP_RESET = 16'd1000;

   // releases per service beat
   localparam int MAX_RESULTS = 16;
   localparam int REL_CNT_W   = $clog2(MAX_RESULTS + 1);

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] now_time;
      logic [7:0]  speaker_tag;
      logic [15:0] sound_tag;
      logic [15:0] expire_delay;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  out_speaker;
      logic [15:0] out_sound;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  speaker;
      logic [15:0] sound;
      logic [31:0] expiry;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

endpackage

// ----- hw/rtl/pef_slot_ram.sv -----
module pef_slot_ram
   import pef_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  slot_type      wr_data,
   input  logic [AW-1:0] rd_addr,
   output slot_type      rd_data
);

   slot_type mem [DEPTH];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/paced_expiring_fifo.sv -----
// Enqueue, clear and refused service are answered in the cycle after the request beat.
// Service: each head entry examined takes a slot RAM read, then a check; the walk
//   closes with one more read, then the stop check; the final result waits in a
//   one-entry hold so last can be set.
// Throughput: one request at a time; enqueue/clear: a beat each cycle when unstalled.
// Reset: synchronous, active high; clears control state, leaves slot RAM contents.
module paced_expiring_fifo
   import pef_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   // configuration writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [HW-1:0] HEAD_LAST = HW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] COUNT_FULL = CW'(QUEUE_DEPTH);
   localparam logic [HW:0]   DEPTH_EXT = (HW + 1)'(QUEUE_DEPTH);
   localparam logic [REL_CNT_W-1:0] REL_MAX = REL_CNT_W'(MAX_RESULTS);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_READ  = 3'b010,
      ST_CHECK = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [HW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   next_ff, next_in;        // next allowed release time
   logic          skip_ff, skip_in;
   logic [15:0]   gap_ff, gap_in;
   logic [31:0]   now_ff, now_in;          // time of the service in progress
   logic [REL_CNT_W-1:0] nrel_ff, nrel_in; // releases so far in this service
   logic          pend_valid_ff, pend_valid_in;
   slot_type      pend_ff, pend_in;        // latest release, held until last is known
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          wr_en;
   slot_type      wr_slot;
   slot_type      rd_slot;
   logic [HW-1:0] tail;
   logic [HW:0]   tail_sum;
   logic [HW-1:0] head_inc;
   logic          out_free;
   logic          stop;

   // one slot RAM, written at the tail, read at the head every cycle
   pef_slot_ram #(
      .DEPTH (QUEUE_DEPTH),
      .AW    (HW)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail),
      .wr_data (wr_slot),
      .rd_addr (head_ff),
      .rd_data (rd_slot)
   );

   // tail = (head + count) mod depth; the sum stays below twice the depth
   assign tail_sum = {1'b0, head_ff} + (HW + 1)'(count_ff);
   assign tail     = (tail_sum >= DEPTH_EXT) ? HW'(tail_sum - DEPTH_EXT) : HW'(tail_sum);
   assign head_inc = (head_ff == HEAD_LAST) ? '0 : head_ff + 1'b1;

   assign wr_slot.speaker = req_data.speaker_tag;
   assign wr_slot.sound   = req_data.sound_tag;
   assign wr_slot.expiry  = req_data.now_time + {16'd0, req_data.expire_delay};

   // output register can take a new beat this edge
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // popping ends on empty queue, result limit or pacing
   assign stop = (count_ff == '0) || (nrel_ff == REL_MAX) || (now_ff < next_ff);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      next_in       = next_ff;
      skip_in       = skip_ff;
      gap_in        = gap_ff;
      now_in        = now_ff;
      nrel_in       = nrel_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SKIP_ALL: skip_in = csr_wdata[0];
            CSR_MIN_GAP:  gap_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{KIND_NONE, 8'd0, 16'd0, 1'b1};
               case (req_data.func)
                  FUNC_ENQUEUE: begin
                     if (skip_ff || (count_ff >= COUNT_FULL)) begin
                        rsp_in.result_kind = KIND_REFUSED;
                     end else begin
                        wr_en              = 1'b1;
                        count_in           = count_ff + 1'b1;
                        rsp_in.result_kind = KIND_ACCEPTED;
                     end
                  end
                  FUNC_CLEAR: begin
                     head_in  = '0;
                     count_in = '0;
                  end
                  FUNC_SERVICE: begin
                     if (!skip_ff) begin
                        // results come from the pop loop instead
                        rsp_valid_in  = 1'b0;
                        now_in        = req_data.now_time;
                        nrel_in       = '0;
                        pend_valid_in = 1'b0;
                        state_in      = ST_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_READ: begin
            // head slot read in flight
            state_in = ST_CHECK;
         end

         ST_CHECK: begin
            if (stop) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  if (pend_valid_ff) begin
                     rsp_in = '{KIND_RELEASED, pend_ff.speaker, pend_ff.sound, 1'b1};
                  end else begin
                     rsp_in = '{KIND_NONE, 8'd0, 16'd0, 1'b1};
                  end
                  pend_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else if (now_ff > rd_slot.expiry) begin
               // expired: drop silently
               head_in  = head_inc;
               count_in = count_ff - 1'b1;
               state_in = ST_READ;
            end else if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{KIND_RELEASED, pend_ff.speaker, pend_ff.sound, 1'b0};
               end
               pend_in       = rd_slot;
               pend_valid_in = 1'b1;
               nrel_in       = nrel_ff + 1'b1;
               head_in       = head_inc;
               count_in      = count_ff - 1'b1;
               next_in       = now_ff + {16'd0, gap_ff};
               state_in      = ST_READ;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         next_ff       <= '0;
         skip_ff       <= 1'b0;
         gap_ff        <= MIN_GAP_RESET;
         nrel_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         next_ff       <= next_in;
         skip_ff       <= skip_in;
         gap_ff        <= gap_in;
         nrel_ff       <= nrel_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      now_ff  <= now_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

endmodule

// ----- dv/paced_expiring_fifo_test.sv -----
module paced_expiring_fifo_test
   import pef_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 16;
   localparam int RAND_ITEMS = 120;
   localparam int HOLD_OFF_CYCLES = 400;   // long output hold-off, stalls the request side
   localparam int CSR_SETTLE = 4;          // quiet cycles before a register write
   localparam int END_SETTLE = 40;         // covers the longest service walk
   localparam int DRAIN_LIMIT = 50000;

   // func code the block must treat as a no-op
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   // register index with nothing behind it
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   paced_expiring_fifo #(.QUEUE_DEPTH(DEPTH)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Shadow copy of the queue, the pacing timer and the two registers.
   // ------------------------------------------------------------------
   slot_type    ring [DEPTH];
   int unsigned head;
   int unsigned fill;
   logic [31:0] next_ok;
   bit          skip_on;
   logic [15:0] gap;

   rsp_type awaited[$];   // result beats still owed by the block, oldest first

   int fail_count;
   int beats_sent;
   int beats_checked;
   int n_released;
   int n_refused;
   int n_dropped;

   // shared between sender and receiver
   bit no_idle;
   bit hold_off_req;

   logic [31:0] wall;     // running time base for the random part

   // One request beat in, every result beat it owes pushed onto awaited.
   function automatic void queue_react(req_type r);
      rsp_type     b;
      rsp_type     rel;
      int unsigned h;
      int          released;
      released = 0;
      b = '0;
      b.result_kind = KIND_NONE;
      case (r.func)
         FUNC_ENQUEUE: begin
            if (skip_on || fill >= DEPTH) begin
               b.result_kind = KIND_REFUSED;
               n_refused++;
            end else begin
               ring[(head + fill) % DEPTH] = '{speaker: r.speaker_tag,
                                               sound:   r.sound_tag,
                                               expiry:  r.now_time + 32'(r.expire_delay)};
               fill++;
               b.result_kind = KIND_ACCEPTED;
            end
         end
         FUNC_CLEAR: begin
            // pacing timer survives a clear
            head = 0;
            fill = 0;
         end
         FUNC_SERVICE: begin
            if (!skip_on) begin
               while (fill > 0 && released < MAX_RESULTS && r.now_time >= next_ok) begin
                  h = head;
                  head = (head + 1) % DEPTH;
                  fill--;
                  if (r.now_time > ring[h].expiry) begin
                     n_dropped++;
                  end else begin
                     rel = '0;
                     rel.result_kind = KIND_RELEASED;
                     rel.out_speaker = ring[h].speaker;
                     rel.out_sound   = ring[h].sound;
                     awaited.push_back(rel);
                     released++;
                     n_released++;
                     next_ok = r.now_time + 32'(gap);
                  end
               end
            end
         end
         default: ;
      endcase
      if (released == 0) begin
         b.last = 1'b1;
         awaited.push_back(b);
      end else begin
         awaited[$].last = 1'b1;
      end
   endfunction

   function automatic void log_fault(string what, rsp_type want, rsp_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("[%0t] %s: expected kind=%0d spk=%02h snd=%04h last=%0b, %s",
                  $time, what, want.result_kind, want.out_speaker, want.out_sound, want.last,
                  $sformatf("got kind=%0d spk=%02h snd=%04h last=%0b",
                            got.result_kind, got.out_speaker, got.out_sound, got.last));
   endfunction

   // Random content for a beat; fields the block ignores get noise too.
   function automatic req_type make_beat(logic [1:0] f, logic [31:0] t);
      req_type r;
      r.func        = f;
      r.now_time    = t;
      r.speaker_tag = 8'($urandom);
      r.sound_tag   = 16'($urandom);
      case ($urandom_range(3))
         0:       r.expire_delay = 16'($urandom_range(0, 20));
         1, 2:    r.expire_delay = 16'($urandom_range(0, 3000));
         default: r.expire_delay = 16'($urandom);
      endcase
      return r;
   endfunction

   // Half the services step up to twice the current gap plus 100, the rest up to 300.
   function automatic void step_wall_for_service();
      if ($urandom_range(1) == 1)
         wall += $urandom_range(0, 2 * int'(gap) + 100);
      else
         wall += $urandom_range(0, 300);
   endfunction

   // ------------------------------------------------------------------
   // Directed plan: one row per request beat or register write.
   // ------------------------------------------------------------------
   typedef struct {
      bit                    is_csr;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] val;
      req_type               req;
      bit                    typed;   // want holds the single expected kind
      logic [1:0]            want;
   } plan_row_type;

   plan_row_type plan[$];

   function automatic plan_row_type req_row(logic [1:0] f, logic [31:0] t, logic [7:0] spk,
                                            logic [15:0] snd, logic [15:0] dly,
                                            bit typed = 1'b0,
                                            logic [1:0] want = KIND_NONE);
      plan_row_type p;
      p.is_csr = 1'b0;
      p.idx    = '0;
      p.val    = '0;
      p.req    = '{func: f, now_time: t, speaker_tag: spk, sound_tag: snd, expire_delay: dly};
      p.typed  = typed;
      p.want   = want;
      return p;
   endfunction

   function automatic plan_row_type csr_row(logic [CSR_IDX_W-1:0] idx,
                                            logic [CSR_DATA_W-1:0] val);
      plan_row_type p;
      p.is_csr = 1'b1;
      p.idx    = idx;
      p.val    = val;
      p.req    = '0;
      p.typed  = 1'b0;
      p.want   = KIND_NONE;
      return p;
   endfunction

   // ------------------------------------------------------------------
   // Sender side. Every task starts and ends at a falling edge.
   // ------------------------------------------------------------------

   // Offer one beat; valid only drops during random idles, never on stall.
   task automatic offer(input req_type r, input bit typed = 1'b0,
                        input logic [1:0] want = KIND_NONE);
      rsp_type fixed;
      while (!no_idle && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      queue_react(r);
      if (typed) begin
         // hand-written expectation replaces the shadow's single beat
         fixed = '0;
         fixed.result_kind = want;
         fixed.last = 1'b1;
         awaited[$] = fixed;
      end
      beats_sent++;
      @(negedge clock);
   endtask

   // Registers only change once the block has answered everything.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      req_valid <= 1'b0;
      while (awaited.size() != 0) @(negedge clock);
      repeat (CSR_SETTLE) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SKIP_ALL: skip_on = val[0];
         CSR_MIN_GAP:  gap = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mixed traffic: mostly enqueue and service, some clears and no-ops.
   task automatic random_item(inout int counted);
      int      pick;
      req_type r;
      pick = $urandom_range(99);
      if (pick < 45) begin
         wall += $urandom_range(0, 400);
         r = make_beat(FUNC_ENQUEUE, wall);
         if ($urandom_range(19) == 0) r.now_time = $urandom;   // out-of-order time
      end else if (pick < 85) begin
         step_wall_for_service();
         r = make_beat(FUNC_SERVICE, wall);
         if ($urandom_range(9) == 0) r.now_time = $urandom_range(0, wall);   // stale time
      end else if (pick < 93) begin
         r = make_beat(FUNC_CLEAR, wall);
      end else begin
         r = make_beat(FUNC_UNUSED, $urandom);
      end
      offer(r);
      if (r.func != FUNC_UNUSED) counted++;
   endtask

   // ------------------------------------------------------------------
   // Clock and reset
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Receiver: random stall, quiet stretch, and one long hold-off.
   // ------------------------------------------------------------------
   initial begin
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_done) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(99) < 23);
         end
      end
   end

   // Result check: every accepted beat against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_checked++;
         if (awaited.size() == 0) begin
            log_fault("unexpected result beat", '0, rsp_data);
         end else begin
            want = awaited.pop_front();
            if (rsp_data.result_kind !== want.result_kind ||
                rsp_data.out_speaker !== want.out_speaker ||
                rsp_data.out_sound   !== want.out_sound   ||
                rsp_data.last        !== want.last)
               log_fault("result mismatch", want, rsp_data);
         end
      end
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int          rand_items;
      int          directed_beats;
      int          spin;
      int          n;
      logic [15:0] g;

      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset     = 1'b1;

      head = 0;
      fill = 0;
      next_ok = '0;
      skip_on = 1'b0;
      gap = MIN_GAP_RESET;
      fail_count = 0;
      beats_sent = 0;
      beats_checked = 0;
      n_released = 0;
      n_refused = 0;
      n_dropped = 0;
      no_idle = 1'b0;
      hold_off_req = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset state: gap 1000, skip off, timer at 0.
      plan.push_back(req_row(FUNC_SERVICE, 32'h0, 8'h00, 16'h0000, 16'h0000, 1'b1, KIND_NONE));
      plan.push_back(req_row(FUNC_CLEAR, 32'h0, 8'h00, 16'h0000, 16'h0000, 1'b1, KIND_NONE));
      plan.push_back(req_row(FUNC_UNUSED, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                             1'b1, KIND_NONE));
      // field extremes, expiry that wraps past 2^32
      plan.push_back(req_row(FUNC_ENQUEUE, 32'h0, 8'hFF, 16'hFFFF, 16'hFFFF,
                             1'b1, KIND_ACCEPTED));
      plan.push_back(req_row(FUNC_ENQUEUE, 32'hFFFF_FFFF, 8'h00, 16'h0000, 16'h0000,
                             1'b1, KIND_ACCEPTED));
      plan.push_back(req_row(FUNC_ENQUEUE, 32'hFFFF_FFFF, 8'h5A, 16'hA5A5, 16'hFFFF,
                             1'b1, KIND_ACCEPTED));
      // release one, then blocked by the gap, then next after the gap
      plan.push_back(req_row(FUNC_SERVICE, 32'd100, 8'h00, 16'h0000, 16'h0000));
      plan.push_back(req_row(FUNC_SERVICE, 32'd500, 8'h00, 16'h0000, 16'h0000));
      plan.push_back(req_row(FUNC_SERVICE, 32'h0001_0000, 8'h00, 16'h0000, 16'h0000));
      // gap 0: wrapped entry is expired and dropped silently
      plan.push_back(csr_row(CSR_MIN_GAP, 16'h0000));
      plan.push_back(req_row(FUNC_SERVICE, 32'h0002_0000, 8'h00, 16'h0000, 16'h0000));
      // live, expired, live: two releases in one service
      plan.push_back(req_row(FUNC_ENQUEUE, 32'h0002_0000, 8'h11, 16'h1111, 16'd100));
      plan.push_back(req_row(FUNC_ENQUEUE, 32'h0002_0000, 8'h22, 16'h2222, 16'd0));
      plan.push_back(req_row(FUNC_ENQUEUE, 32'h0002_0000, 8'h33, 16'h3333, 16'd200));
      plan.push_back(req_row(FUNC_SERVICE, 32'h0002_0010, 8'h00, 16'h0000, 16'h0000));
      // write to an index with no register behind it
      plan.push_back(csr_row(CSR_UNMAPPED, 16'hFFFF));
      // skip switch: refuse, no service, clear still answers
      plan.push_back(csr_row(CSR_SKIP_ALL, 16'h0001));
      plan.push_back(req_row(FUNC_ENQUEUE, 32'h0002_0020, 8'h77, 16'h7777, 16'd50,
                             1'b1, KIND_REFUSED));
      plan.push_back(req_row(FUNC_SERVICE, 32'h0002_0030, 8'h00, 16'h0000, 16'h0000,
                             1'b1, KIND_NONE));
      plan.push_back(req_row(FUNC_CLEAR, 32'h0002_0030, 8'h00, 16'h0000, 16'h0000,
                             1'b1, KIND_NONE));
      // widest gap, then a service after a clear that emptied the queue
      plan.push_back(csr_row(CSR_SKIP_ALL, 16'h0000));
      plan.push_back(csr_row(CSR_MIN_GAP, 16'hFFFF));
      plan.push_back(req_row(FUNC_ENQUEUE, 32'h0003_0000, 8'h44, 16'h4444, 16'd50,
                             1'b1, KIND_ACCEPTED));
      plan.push_back(req_row(FUNC_ENQUEUE, 32'h0003_0000, 8'h55, 16'h5555, 16'hFFFF,
                             1'b1, KIND_ACCEPTED));
      plan.push_back(req_row(FUNC_SERVICE, 32'h0003_0010, 8'h00, 16'h0000, 16'h0000));
      plan.push_back(req_row(FUNC_CLEAR, 32'h0003_0010, 8'h00, 16'h0000, 16'h0000,
                             1'b1, KIND_NONE));
      plan.push_back(req_row(FUNC_SERVICE, 32'h0003_0020, 8'h00, 16'h0000, 16'h0000));

      foreach (plan[i]) begin
         if (plan[i].is_csr)
            write_csr(plan[i].idx, plan[i].val);
         else
            offer(plan[i].req, plan[i].typed, plan[i].want);
      end
      directed_beats = beats_sent;

      // Random phases. Each phase may retune the registers first, then runs
      // either a fill-and-drain burst or mixed traffic.
      wall = 32'h0010_0000;
      rand_items = 0;
      while (rand_items < RAND_ITEMS) begin
         if (skip_on)
            write_csr(CSR_SKIP_ALL, 16'h0000);
         else if ($urandom_range(7) == 0)
            write_csr(CSR_SKIP_ALL, 16'h0001);
         if ($urandom_range(2) == 0) begin
            case ($urandom_range(5))
               0, 1, 2: g = 16'h0000;
               3:       g = 16'($urandom_range(1, 300));
               4:       g = 16'hFFFF;
               default: g = 16'($urandom);
            endcase
            write_csr(CSR_MIN_GAP, g);
         end

         // a stretch with no idling on either side
         no_idle = (rand_items >= 60 && rand_items < 100);

         if ($urandom_range(9) < 4) begin
            // first burst past the warm-up runs under the long output hold-off
            if (!hold_off_req && rand_items >= 30) hold_off_req = 1'b1;
            n = $urandom_range(6, 20);
            repeat (n) begin
               wall += $urandom_range(0, 50);
               offer(make_beat(FUNC_ENQUEUE, wall));
               rand_items++;
            end
            repeat ($urandom_range(1, 4)) begin
               step_wall_for_service();
               offer(make_beat(FUNC_SERVICE, wall));
               rand_items++;
            end
         end else begin
            repeat (12) random_item(rand_items);
         end
      end
      no_idle = 1'b0;

      // Drain, then give the block time to show any stray beat.
      req_valid <= 1'b0;
      spin = 0;
      while (awaited.size() != 0 && spin < DRAIN_LIMIT) begin
         @(negedge clock);
         spin++;
      end
      repeat (END_SETTLE) @(negedge clock);
      if (awaited.size() != 0) begin
         fail_count += awaited.size();
         $display("[%0t] %0d expected result beats never arrived", $time, awaited.size());
      end

      $display("Sent %0d request beats (%0d directed); checked %0d result beats.",
               beats_sent, directed_beats, beats_checked);
      $display("%0d released, %0d refused, %0d expired entries dropped.",
               n_released, n_refused, n_dropped);
      $display("Gap settings 0 through 65535, skip on and off, %0d-cycle output hold-off; %s",
               HOLD_OFF_CYCLES, $sformatf("%0d failures.", fail_count));
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
